// File: design/kplp_pkg.sv
package kplp_pkg;

   // default sizing
   localparam int NUM_KEYS_DEF  = 256;
   localparam int TIME_BITS_DEF = 32;

   // csr port sizing
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_MS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTION_KEY    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETURN_KEY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFT_KEY_ONE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFT_KEY_TWO  = 3'd4;

   // register reset values
   localparam logic [15:0] LONG_PRESS_MS_RST = 16'd400;
   localparam logic [7:0]  ACTION_KEY_RST    = 8'd134;
   localparam logic [7:0]  RETURN_KEY_RST    = 8'd13;
   localparam logic [7:0]  SOFT_KEY_ONE_RST  = 8'd112;
   localparam logic [7:0]  SOFT_KEY_TWO_RST  = 8'd113;

   // key codes that never track state
   localparam logic [7:0] IGNORED_KEY_A = 8'd91;
   localparam logic [7:0] IGNORED_KEY_B = 8'd132;

   typedef enum logic [1:0] {
      OP_DOWN = 2'd0,
      OP_UP   = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_PRESS = 2'd1,
      KIND_LONG  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_UP   = 2'd1,
      ST_SCAN = 2'd2
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic do_down;
      logic do_up_issue;
      logic do_up_finish;
      logic do_misc;
      logic scan_init;
      logic scan_run;
      logic scan_finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_hit;
      logic scan_last;
   } sts_type;

endpackage

// File: design/kplp_ram.sv
module kplp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/kplp_ctrl.sv
module kplp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_opcode,
   input  kplp_pkg::sts_type sts,
   output kplp_pkg::cmd_type cmd,
   output logic              busy
);

   kplp_pkg::state_type state_ff;
   kplp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kplp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         kplp_pkg::ST_IDLE: begin
            if (start) begin
               case (req_opcode)
                  kplp_pkg::OP_DOWN: begin
                     cmd.do_down = 1'b1;
                  end
                  kplp_pkg::OP_UP: begin
                     cmd.do_up_issue = 1'b1;
                     state_in        = kplp_pkg::ST_UP;
                  end
                  kplp_pkg::OP_TICK: begin
                     cmd.scan_init = 1'b1;
                     state_in      = kplp_pkg::ST_SCAN;
                  end
                  default: begin
                     cmd.do_misc = 1'b1;
                  end
               endcase
            end
         end
         kplp_pkg::ST_UP: begin
            cmd.do_up_finish = 1'b1;
            state_in         = kplp_pkg::ST_IDLE;
         end
         kplp_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_hit || sts.scan_last) begin
               cmd.scan_finish = 1'b1;
               state_in        = kplp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kplp_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != kplp_pkg::ST_IDLE);

endmodule

// File: design/kplp_dp.sv
module kplp_dp #(
   parameter int NUM_KEYS  = kplp_pkg::NUM_KEYS_DEF,
   parameter int TIME_BITS = kplp_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [7:0]                      req_key_code,
   input  logic [TIME_BITS-1:0]            req_now_ms,
   input  logic                            csr_we,
   input  logic [kplp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kplp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  kplp_pkg::cmd_type               cmd,
   output kplp_pkg::sts_type               sts,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_event_kind,
   output logic [7:0]                      rsp_event_key
);

   localparam int KEY_W = $clog2(NUM_KEYS);
   localparam int CNT_W = KEY_W + 1;

   function automatic logic is_ignored(input logic [7:0] k);
      return ({1'b0, k} >= 9'(NUM_KEYS)) ||
             (k == kplp_pkg::IGNORED_KEY_A) || (k == kplp_pkg::IGNORED_KEY_B);
   endfunction

   // configuration
   logic [15:0] long_ms_ff, long_ms_in;
   logic [7:0]  action_ff, action_in;
   logic [7:0]  return_ff, return_in;
   logic [7:0]  soft1_ff, soft1_in;
   logic [7:0]  soft2_ff, soft2_in;

   // key state
   logic [NUM_KEYS-1:0] held_ff, held_in;
   logic                ldv_ff, ldv_in;
   logic [7:0]          ld_key_ff, ld_key_in;

   // latched item
   logic [7:0]           key_ff, key_in;
   logic [TIME_BITS-1:0] now_ff, now_in;

   // scan pipeline
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [KEY_W-1:0] chk_idx_ff, chk_idx_in;
   logic             chk_valid_ff, chk_valid_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   kplp_pkg::kind_type kind_ff, kind_in;
   logic [7:0]         rsp_key_ff, rsp_key_in;

   // press time memory
   logic                 ram_we;
   logic [KEY_W-1:0]     ram_wa;
   logic [TIME_BITS-1:0] ram_wd;
   logic [KEY_W-1:0]     ram_ra;
   logic [TIME_BITS-1:0] ram_rd;

   logic [KEY_W-1:0]     req_idx;
   logic [KEY_W-1:0]     key_idx;
   logic                 suppress;
   logic [TIME_BITS-1:0] elapsed;
   logic                 is_long;
   logic                 scan_hit;
   logic                 scan_last;

   kplp_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (NUM_KEYS)
   ) u_press_time (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign req_idx  = req_key_code[KEY_W-1:0];
   assign key_idx  = key_ff[KEY_W-1:0];
   assign suppress = ldv_ff && (ld_key_ff == action_ff) && (req_key_code == return_ff);

   // wrapping hold time, shared by key up and scan
   assign elapsed = now_ff - ram_rd;
   assign is_long = (elapsed >= TIME_BITS'(long_ms_ff));

   assign scan_hit  = chk_valid_ff && held_ff[chk_idx_ff] && is_long;
   assign scan_last = chk_valid_ff && (chk_idx_ff == KEY_W'(NUM_KEYS - 1));

   assign sts.scan_hit  = scan_hit;
   assign sts.scan_last = scan_last;

   always_comb begin
      long_ms_in   = long_ms_ff;
      action_in    = action_ff;
      return_in    = return_ff;
      soft1_in     = soft1_ff;
      soft2_in     = soft2_ff;
      held_in      = held_ff;
      ldv_in       = ldv_ff;
      ld_key_in    = ld_key_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      rd_idx_in    = rd_idx_ff;
      chk_idx_in   = chk_idx_ff;
      chk_valid_in = chk_valid_ff;
      rsp_valid_in = 1'b0;
      kind_in      = kind_ff;
      rsp_key_in   = rsp_key_ff;
      ram_we       = 1'b0;
      ram_wa       = req_idx;
      ram_wd       = req_now_ms;
      ram_ra       = cmd.scan_run ? rd_idx_ff[KEY_W-1:0] : req_idx;

      if (csr_we) begin
         case (csr_index)
            kplp_pkg::CSR_LONG_PRESS_MS: long_ms_in = csr_wdata;
            kplp_pkg::CSR_ACTION_KEY:    action_in  = csr_wdata[7:0];
            kplp_pkg::CSR_RETURN_KEY:    return_in  = csr_wdata[7:0];
            kplp_pkg::CSR_SOFT_KEY_ONE:  soft1_in   = csr_wdata[7:0];
            kplp_pkg::CSR_SOFT_KEY_TWO:  soft2_in   = csr_wdata[7:0];
            default: ;
         endcase
      end

      if (cmd.do_down) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = req_key_code;
         kind_in      = kplp_pkg::KIND_NONE;
         if (!suppress && !is_ignored(req_key_code)) begin
            ldv_in           = 1'b1;
            ld_key_in        = req_key_code;
            held_in[req_idx] = 1'b1;
            ram_we           = 1'b1;
            if (held_ff[req_idx]) begin
               kind_in = kplp_pkg::KIND_PRESS;
            end
         end
      end

      if (cmd.do_up_issue) begin
         ldv_in = 1'b0;
         key_in = req_key_code;
         now_in = req_now_ms;
      end

      if (cmd.do_up_finish) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = key_ff;
         kind_in      = kplp_pkg::KIND_NONE;
         if (!is_ignored(key_ff)) begin
            if (held_ff[key_idx]) begin
               held_in[key_idx] = 1'b0;
               kind_in = is_long ? kplp_pkg::KIND_LONG : kplp_pkg::KIND_PRESS;
            end else if ((key_ff == soft1_ff) || (key_ff == soft2_ff)) begin
               kind_in = kplp_pkg::KIND_PRESS;
            end
         end
      end

      if (cmd.do_misc) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = req_key_code;
         kind_in      = kplp_pkg::KIND_NONE;
      end

      if (cmd.scan_init) begin
         rd_idx_in    = '0;
         chk_valid_in = 1'b0;
         now_in       = req_now_ms;
      end

      if (cmd.scan_run) begin
         // read one entry ahead of the check
         chk_idx_in   = rd_idx_ff[KEY_W-1:0];
         chk_valid_in = (rd_idx_ff < CNT_W'(NUM_KEYS));
         if (rd_idx_ff < CNT_W'(NUM_KEYS)) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
         if (cmd.scan_finish) begin
            rsp_valid_in = 1'b1;
            if (scan_hit) begin
               kind_in             = kplp_pkg::KIND_LONG;
               rsp_key_in          = 8'(chk_idx_ff);
               held_in[chk_idx_ff] = 1'b0;
            end else begin
               kind_in    = kplp_pkg::KIND_NONE;
               rsp_key_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ms_ff   <= kplp_pkg::LONG_PRESS_MS_RST;
         action_ff    <= kplp_pkg::ACTION_KEY_RST;
         return_ff    <= kplp_pkg::RETURN_KEY_RST;
         soft1_ff     <= kplp_pkg::SOFT_KEY_ONE_RST;
         soft2_ff     <= kplp_pkg::SOFT_KEY_TWO_RST;
         held_ff      <= '0;
         ldv_ff       <= 1'b0;
         ld_key_ff    <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         long_ms_ff   <= long_ms_in;
         action_ff    <= action_in;
         return_ff    <= return_in;
         soft1_ff     <= soft1_in;
         soft2_ff     <= soft2_in;
         held_ff      <= held_in;
         ldv_ff       <= ldv_in;
         ld_key_ff    <= ld_key_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      now_ff     <= now_in;
      rd_idx_ff  <= rd_idx_in;
      chk_idx_ff <= chk_idx_in;
      kind_ff    <= kind_in;
      rsp_key_ff <= rsp_key_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_event_key  = rsp_key_ff;

endmodule

// File: design/key_press_long_press_classifier.sv
// key down and unused opcode: result in the cycle after start, busy stays low (one item a cycle)
// key up: result registered after the ST_UP state, busy high for one cycle (press time memory read)
// tick: result registered when the scan ends; the scan reads one press time per cycle
// each result shows for one cycle on rsp_valid; the receiver cannot stall
// synchronous reset clears all held flags and the last key down, and returns the csr
// registers to their defaults; press times need no clearing, they are only read behind a held flag
module key_press_long_press_classifier #(
   parameter int NUM_KEYS  = kplp_pkg::NUM_KEYS_DEF,
   parameter int TIME_BITS = kplp_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,

   // item in
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_opcode,
   input  logic [7:0]                      req_key_code,
   input  logic [TIME_BITS-1:0]            req_now_ms,

   // result out
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_event_kind,
   output logic [7:0]                      rsp_event_key,

   // csr write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kplp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kplp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   kplp_pkg::cmd_type cmd;
   kplp_pkg::sts_type sts;

   // csr writes must come only while idle, which the block does not enforce; they are always taken
   assign csr_ready = 1'b1;

   // sequencer: picks the operation and walks the scan
   kplp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   // datapath: csr registers, held flags, press time memory, hold time compare
   kplp_dp #(
      .NUM_KEYS  (NUM_KEYS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_key_code   (req_key_code),
      .req_now_ms     (req_now_ms),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_event_kind (rsp_event_kind),
      .rsp_event_key  (rsp_event_key)
   );

endmodule
